### rtl/core/tbdp_pkg.sv
// Shared types and codes for the tournament branch direction predictor.
package tbdp_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_MULTI  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_PERFECT  = 3'd0,
    MODE_TAKEN    = 3'd1,
    MODE_NOTTAKEN = 3'd2,
    MODE_BIMODAL  = 3'd3,
    MODE_TWOLEVEL = 3'd4,
    MODE_COMBINED = 3'd5
  } mode_t;

  localparam logic [1:0] CTR_RESET = 2'd2;

  // Saturating 2-bit counter step.
  function automatic logic [1:0] sat_move(input logic [1:0] c, input logic up);
    logic [1:0] r;
    if (up) r = (c == 2'd3) ? 2'd3 : c + 2'd1;
    else    r = (c == 2'd0) ? 2'd0 : c - 2'd1;
    return r;
  endfunction

endpackage

### rtl/core/tournament_branch_direction_predictor.sv
// Tournament branch direction predictor top level.
// Items are taken one at a time. A lookup or update has an accept edge, a
// synchronous table read, and a step to form the result or write back
// counters. The input is ready again in the cycle the result appears. In a
// multi-lookup the chain length is multi_count clamped to 1..MAX_CHAIN, and
// chaining happens only in MODE_TWOLEVEL. Each chained prediction after the
// first has its pattern-table read in S_CHAIN and is captured in S_CATCH. A
// result that the sink has not yet taken holds the next lookup in S_EXEC until
// the output register is free. After reset a clearing pass over
// max(BIMODAL_ENTRIES, CHOICE_ENTRIES, HISTORY_ENTRIES,
// PATTERN_COLUMNS << HISTORY_BITS) addresses (4096 with the defaults) sets all
// tables to their reset values, and no item is accepted during it.
// Configuration writes are taken at any time.
module tournament_branch_direction_predictor #(
  parameter int BIMODAL_ENTRIES = 1024,
  parameter int CHOICE_ENTRIES  = 1024,
  parameter int HISTORY_ENTRIES = 1,
  parameter int PATTERN_COLUMNS = 16,
  parameter int HISTORY_BITS    = 8,
  parameter int MAX_CHAIN       = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_data,       // predictor_mode
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[1:0], pc[33:2], next_pc[65:34], instr_size[69:66], unconditional[70],
  // internal_branch[71], saved_history[79:72], saved_bimodal_pred[80],
  // saved_two_level_dir[81], saved_choice[82], multi_count[86:83], zero[87]
  input  logic [87:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // prediction[0], bimodal_pred[1], two_level_dir[2], use_two_level[3],
  // history_row[11:4], multi_predictions[19:12], zero[23:20]
  output logic [23:0]  out_tdata
);

  localparam int PAT_ENTRIES = PATTERN_COLUMNS << HISTORY_BITS;
  localparam int BW = (BIMODAL_ENTRIES > 1) ? $clog2(BIMODAL_ENTRIES) : 1;
  localparam int CW = (CHOICE_ENTRIES > 1) ? $clog2(CHOICE_ENTRIES) : 1;
  localparam int HW = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
  localparam int PW = (PAT_ENTRIES > 1) ? $clog2(PAT_ENTRIES) : 1;
  localparam int M1 = (BIMODAL_ENTRIES > CHOICE_ENTRIES) ? BIMODAL_ENTRIES : CHOICE_ENTRIES;
  localparam int M2 = (M1 > HISTORY_ENTRIES) ? M1 : HISTORY_ENTRIES;
  localparam int CLR_MAX = (M2 > PAT_ENTRIES) ? M2 : PAT_ENTRIES;
  localparam int KW = $clog2(CLR_MAX + 1);
  localparam int NW = $clog2(MAX_CHAIN + 1);
  localparam logic [HISTORY_BITS-1:0] HMASK = '1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_CHAIN, S_CATCH} state_t;

  // Memories
  logic [1:0]              bim_mem [BIMODAL_ENTRIES];
  logic [1:0]              cho_mem [CHOICE_ENTRIES];
  logic [HISTORY_BITS-1:0] his_mem [HISTORY_ENTRIES];
  logic [1:0]              pat_mem [PAT_ENTRIES];
  logic [1:0]              bim_q, cho_q, pat_q;
  logic [HISTORY_BITS-1:0] his_q;

  state_t state_r;
  logic [2:0]  mode_r;
  logic [KW-1:0] clr_r;
  logic [1:0]  cmd_r;
  logic [31:0] pc_r;
  logic        taken_r, skip_r, sbim_r, stwo_r, scho_r;
  logic [HISTORY_BITS-1:0] shist_r, bhr_r;
  logic [NW-1:0] cnt_r, idx_r;
  logic [7:0]  chain_r;
  logic        pred_r, bim_r, two_r, cho_r;
  logic [7:0]  row_r;

  // Read and write controls
  logic          bim_we, cho_we, his_we, pat_we, pat_re;
  logic [BW-1:0] bim_wa; logic [CW-1:0] cho_wa; logic [HW-1:0] his_wa;
  logic [PW-1:0] pat_wa, pat_ra;
  logic [1:0]    bim_wd, cho_wd, pat_wd;
  logic [HISTORY_BITS-1:0] his_wd;

  logic [31:0] in_pc;
  assign in_pc = in_tdata[33:2];
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);

  function automatic logic [PW-1:0] pidx(input logic [HISTORY_BITS-1:0] row,
                                         input logic [31:0] pc);
    logic [PW+31:0] v;
    v = PW'(row) * PW'(PATTERN_COLUMNS) + PW'(pc % PATTERN_COLUMNS);
    return v[PW-1:0];
  endfunction

  logic [HISTORY_BITS-1:0] hrow, bhr_nxt;
  logic t_c;
  assign hrow = his_q & HMASK;
  assign t_c = pat_q > 2'd1;
  assign bhr_nxt = HISTORY_BITS'({bhr_r, t_c});

  // Write controls for the clearing pass and updates, and the pattern read address in S_READ and S_CHAIN.
  always_comb begin
    bim_we = 1'b0; cho_we = 1'b0; his_we = 1'b0; pat_we = 1'b0;
    bim_wa = BW'(pc_r % BIMODAL_ENTRIES);
    cho_wa = CW'(pc_r % CHOICE_ENTRIES);
    his_wa = HW'(pc_r % HISTORY_ENTRIES);
    pat_wa = pidx(shist_r, pc_r);
    bim_wd = tbdp_pkg::sat_move(bim_q, taken_r);
    cho_wd = tbdp_pkg::sat_move(cho_q, !((sbim_r) == taken_r));
    pat_wd = tbdp_pkg::sat_move(pat_q, taken_r);
    his_wd = HISTORY_BITS'({his_q, taken_r});
    pat_re = 1'b0;
    pat_ra = pidx(shist_r, pc_r);
    if (state_r == S_CLEAR) begin
      bim_we = clr_r < KW'(BIMODAL_ENTRIES); bim_wa = BW'(clr_r);
      cho_we = clr_r < KW'(CHOICE_ENTRIES);  cho_wa = CW'(clr_r);
      his_we = clr_r < KW'(HISTORY_ENTRIES); his_wa = HW'(clr_r);
      pat_we = clr_r < KW'(PAT_ENTRIES);     pat_wa = PW'(clr_r);
      bim_wd = tbdp_pkg::CTR_RESET; cho_wd = tbdp_pkg::CTR_RESET;
      pat_wd = tbdp_pkg::CTR_RESET; his_wd = '0;
    end else if (state_r == S_READ) begin
      // Pattern read needs the history row except for update.
      pat_re = 1'b1;
      pat_ra = (cmd_r == tbdp_pkg::CMD_UPDATE) ? pidx(shist_r, pc_r) : pidx(hrow, pc_r);
    end else if (state_r == S_EXEC && cmd_r == tbdp_pkg::CMD_UPDATE && !skip_r) begin
      bim_we = (mode_r == tbdp_pkg::MODE_BIMODAL) ||
               (mode_r == tbdp_pkg::MODE_COMBINED && !scho_r);
      his_we = (mode_r == tbdp_pkg::MODE_TWOLEVEL) ||
               (mode_r == tbdp_pkg::MODE_COMBINED && scho_r);
      pat_we = his_we;
      cho_we = (mode_r == tbdp_pkg::MODE_COMBINED) && (sbim_r != stwo_r);
    end else if (state_r == S_CHAIN) begin
      pat_re = 1'b1;
      pat_ra = pidx(bhr_nxt, pc_r);
    end
  end

  // Memory ports: history and small tables read in S_IDLE, pattern on demand.
  always_ff @(posedge clk) begin
    if (bim_we) bim_mem[bim_wa] <= bim_wd;
    if (cho_we) cho_mem[cho_wa] <= cho_wd;
    if (his_we) his_mem[his_wa] <= his_wd;
    if (pat_we) pat_mem[pat_wa] <= pat_wd;
    if (state_r == S_IDLE) begin
      bim_q <= bim_mem[BW'(in_pc % BIMODAL_ENTRIES)];
      cho_q <= cho_mem[CW'(in_pc % CHOICE_ENTRIES)];
      his_q <= his_mem[HW'(in_pc % HISTORY_ENTRIES)];
    end
    if (pat_re) pat_q <= pat_mem[pat_ra];
  end

  logic [3:0] cnt_in;
  logic [NW-1:0] cnt_sat;
  assign cnt_in = in_tdata[86:83];
  always_comb begin
    if (cnt_in == 4'd0) cnt_sat = NW'(1);
    else if (32'(cnt_in) > MAX_CHAIN) cnt_sat = NW'(MAX_CHAIN);
    else cnt_sat = NW'(cnt_in);
  end

  // Form the result fields of a lookup or the first multi-lookup prediction
  logic       res_pred, res_bim, res_two, res_cho;
  logic [7:0] res_row;
  always_comb begin
    res_pred = 1'b0; res_bim = 1'b0; res_two = 1'b0; res_cho = 1'b0; res_row = '0;
    if (cmd_r == tbdp_pkg::CMD_LOOKUP) begin
      if (skip_r) begin
        res_pred = 1'b1;
      end else begin
        case (mode_r)
          tbdp_pkg::MODE_PERFECT: res_pred = taken_r;
          tbdp_pkg::MODE_TAKEN:   res_pred = 1'b1;
          tbdp_pkg::MODE_BIMODAL: begin
            res_bim = bim_q > 2'd1; res_pred = bim_q > 2'd1;
          end
          tbdp_pkg::MODE_TWOLEVEL: begin
            res_two = t_c; res_pred = t_c; res_row = 8'(bhr_r);
          end
          tbdp_pkg::MODE_COMBINED: begin
            res_bim = bim_q > 2'd1; res_two = t_c; res_row = 8'(bhr_r);
            res_cho = cho_q > 2'd1;
            res_pred = (cho_q > 2'd1) ? t_c : (bim_q > 2'd1);
          end
          default: res_pred = 1'b0;
        endcase
      end
    end else if (mode_r == tbdp_pkg::MODE_TWOLEVEL) begin
      res_pred = t_c; res_two = t_c; res_row = 8'(bhr_r);
    end
  end

  // Output register handoff and chain control
  logic out_free, chain_go, chain_more, res_done;
  assign out_free   = !out_tvalid || out_tready;
  assign chain_go   = (cmd_r == tbdp_pkg::CMD_MULTI) && (mode_r == tbdp_pkg::MODE_TWOLEVEL) &&
                      (cnt_r != NW'(1));
  assign chain_more = (idx_r + NW'(1)) < cnt_r;
  assign res_done   = ((state_r == S_EXEC) && (cmd_r != tbdp_pkg::CMD_UPDATE) && out_free &&
                       !chain_go) || ((state_r == S_CATCH) && !chain_more);

  // Sequencer with registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; mode_r <= tbdp_pkg::MODE_COMBINED; clr_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) mode_r <= cfg_data;
      // Raise the result once formed, drop it once taken
      out_tvalid <= res_done || (out_tvalid && !out_tready);
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + KW'(1);
          if (clr_r == KW'(CLR_MAX - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          cmd_r   <= in_tdata[1:0];
          pc_r    <= in_pc;
          taken_r <= in_tdata[65:34] != (in_pc + {28'd0, in_tdata[69:66]});
          skip_r  <= in_tdata[70] | in_tdata[71];
          shist_r <= HISTORY_BITS'(in_tdata[79:72]) & HMASK;
          sbim_r  <= in_tdata[80]; stwo_r <= in_tdata[81]; scho_r <= in_tdata[82];
          cnt_r   <= cnt_sat;
          if (in_tdata[1:0] == tbdp_pkg::CMD_NONE) state_r <= S_IDLE;
          else state_r <= S_READ;
        end
        S_READ: begin
          bhr_r <= hrow;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd_r == tbdp_pkg::CMD_UPDATE) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            // Load the output register; a chain keeps it until the last bit
            pred_r  <= res_pred; bim_r <= res_bim; two_r <= res_two; cho_r <= res_cho;
            row_r   <= res_row;
            chain_r <= {7'd0, res_two & (cmd_r == tbdp_pkg::CMD_MULTI)};
            idx_r   <= NW'(1);
            state_r <= chain_go ? S_CHAIN : S_IDLE;
          end
        end
        S_CHAIN: begin
          // Advance the speculative history; its pattern read lands next cycle
          bhr_r <= bhr_nxt;
          state_r <= S_CATCH;
        end
        S_CATCH: begin
          // Capture the chained bit from the read issued in S_CHAIN
          if (32'(idx_r) < 8) chain_r[3'(idx_r)] <= t_c;
          idx_r <= idx_r + NW'(1);
          state_r <= chain_more ? S_CHAIN : S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata = {4'd0, chain_r, row_r, cho_r, two_r, bim_r, pred_r};

endmodule

### verif/tb_top.sv
// Self-checking testbench for the tournament branch direction predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [3:0]  multi_count;
    logic        saved_choice;
    logic        saved_two_level_dir;
    logic        saved_bimodal_pred;
    logic [7:0]  saved_history;
    logic        internal_branch;
    logic        unconditional;
    logic [3:0]  instr_size;
    logic [31:0] next_pc;
    logic [31:0] pc;
    tbdp_pkg::cmd_t command;
  } branch_item_t;

  typedef struct packed {
    logic [7:0] multi_predictions;
    logic [7:0] history_row;
    logic       use_two_level;
    logic       two_level_dir;
    logic       bimodal_pred;
    logic       prediction;
  } branch_result_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [87:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [23:0]  out_tdata;

  // Predictor copy of the block state
  logic [2:0] pred_mode;
  logic [1:0] bim_ctr [1024];
  logic [7:0] hist_reg;
  logic [1:0] pat_ctr [4096];
  logic [1:0] cho_ctr [1024];

  branch_result_t expected_results[$];
  int  error_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct;
  int  recv_idle_pct;

  tournament_branch_direction_predictor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [1:0] ctr_step(logic [1:0] c, logic up);
    if (up) return (c == 2'd3) ? 2'd3 : c + 2'd1;
    return (c == 2'd0) ? 2'd0 : c - 2'd1;
  endfunction

  // Work out the result of one item and advance the predictor state
  task automatic predict_branch(input branch_item_t it);
    branch_result_t r;
    logic taken, p;
    logic [7:0] row, sh;
    logic [3:0] cnt;
    int pi;
    r = '0;
    taken = it.next_pc != it.pc + 32'(it.instr_size);
    sh = it.saved_history;
    case (it.command)
      tbdp_pkg::CMD_LOOKUP: begin
        if (it.unconditional || it.internal_branch) begin
          r.prediction = 1'b1;
        end else begin
          if (pred_mode == tbdp_pkg::MODE_PERFECT) r.prediction = taken;
          else if (pred_mode == tbdp_pkg::MODE_TAKEN) r.prediction = 1'b1;
          if (pred_mode == tbdp_pkg::MODE_BIMODAL || pred_mode == tbdp_pkg::MODE_COMBINED) begin
            r.bimodal_pred = bim_ctr[it.pc[9:0]] > 2'd1;
            r.prediction = r.bimodal_pred;
          end
          if (pred_mode == tbdp_pkg::MODE_TWOLEVEL ||
              pred_mode == tbdp_pkg::MODE_COMBINED) begin
            r.history_row = hist_reg;
            r.two_level_dir = pat_ctr[{hist_reg, it.pc[3:0]}] > 2'd1;
            r.prediction = r.two_level_dir;
          end
          if (pred_mode == tbdp_pkg::MODE_COMBINED) begin
            r.use_two_level = cho_ctr[it.pc[9:0]] > 2'd1;
            r.prediction = r.use_two_level ? r.two_level_dir : r.bimodal_pred;
          end
        end
        expected_results.push_back(r);
      end
      tbdp_pkg::CMD_UPDATE: begin
        if (!(pred_mode == tbdp_pkg::MODE_PERFECT || pred_mode > tbdp_pkg::MODE_COMBINED ||
              it.unconditional || it.internal_branch)) begin
          if (pred_mode == tbdp_pkg::MODE_BIMODAL ||
              (pred_mode == tbdp_pkg::MODE_COMBINED && !it.saved_choice))
            bim_ctr[it.pc[9:0]] = ctr_step(bim_ctr[it.pc[9:0]], taken);
          if (pred_mode == tbdp_pkg::MODE_TWOLEVEL ||
              (pred_mode == tbdp_pkg::MODE_COMBINED && it.saved_choice)) begin
            pi = int'({sh, it.pc[3:0]});
            hist_reg = {hist_reg[6:0], taken};
            pat_ctr[pi] = ctr_step(pat_ctr[pi], taken);
          end
          if (pred_mode == tbdp_pkg::MODE_COMBINED &&
              it.saved_bimodal_pred != it.saved_two_level_dir)
            cho_ctr[it.pc[9:0]] = ctr_step(cho_ctr[it.pc[9:0]],
                                           it.saved_bimodal_pred != taken);
        end
      end
      tbdp_pkg::CMD_MULTI: begin
        if (pred_mode == tbdp_pkg::MODE_TWOLEVEL) begin
          cnt = it.multi_count;
          if (cnt == 4'd0) cnt = 4'd1;
          if (cnt > 4'd8) cnt = 4'd8;
          row = hist_reg;
          r.history_row = row;
          p = pat_ctr[{row, it.pc[3:0]}] > 2'd1;
          r.prediction = p;
          r.two_level_dir = p;
          r.multi_predictions[0] = p;
          for (int i = 1; i < cnt; i++) begin
            row = {row[6:0], p};
            p = pat_ctr[{row, it.pc[3:0]}] > 2'd1;
            r.multi_predictions[i] = p;
          end
        end
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    branch_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[19:0];
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.prediction !== want.prediction)
          $display("%0t prediction: expected %b, actual %b", $time, want.prediction,
                   got.prediction);
        if (got.bimodal_pred !== want.bimodal_pred)
          $display("%0t bimodal_pred: expected %b, actual %b", $time, want.bimodal_pred,
                   got.bimodal_pred);
        if (got.two_level_dir !== want.two_level_dir)
          $display("%0t two_level_dir: expected %b, actual %b", $time, want.two_level_dir,
                   got.two_level_dir);
        if (got.use_two_level !== want.use_two_level)
          $display("%0t use_two_level: expected %b, actual %b", $time, want.use_two_level,
                   got.use_two_level);
        if (got.history_row !== want.history_row)
          $display("%0t history_row: expected %h, actual %h", $time, want.history_row,
                   got.history_row);
        if (got.multi_predictions !== want.multi_predictions)
          $display("%0t multi_predictions: expected %h, actual %h", $time,
                   want.multi_predictions, got.multi_predictions);
        if (got !== want) error_count++;
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one item, with random idle cycles before it
  task automatic send_branch(input branch_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tdata  <= {1'b0, it};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_branch(it);
  endtask

  // Wait out every expected result, then let the block settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [2:0] m);
    drain_results();
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred_mode = m;
    cfg_valid <= 1'b0;
  endtask

  function automatic branch_item_t random_branch(input logic [31:0] pc_base);
    branch_item_t it;
    it.command = tbdp_pkg::cmd_t'($urandom_range(99) < 45 ? tbdp_pkg::CMD_LOOKUP :
                   ($urandom_range(99) < 80 ? tbdp_pkg::CMD_UPDATE :
                    ($urandom_range(9) == 0 ? tbdp_pkg::CMD_NONE : tbdp_pkg::CMD_MULTI)));
    it.pc = ($urandom_range(3) == 0) ? $urandom() : pc_base + 32'($urandom_range(63));
    it.instr_size = 4'($urandom_range(15));
    if (it.instr_size == 4'd0) it.instr_size = 4'd1;
    it.next_pc = $urandom_range(1) ? it.pc + 32'(it.instr_size) : $urandom();
    it.unconditional = ($urandom_range(9) == 0);
    it.internal_branch = ($urandom_range(9) == 0);
    it.saved_history = ($urandom_range(1)) ? hist_reg : 8'($urandom());
    it.saved_bimodal_pred = 1'($urandom_range(1));
    it.saved_two_level_dir = 1'($urandom_range(1));
    it.saved_choice = 1'($urandom_range(1));
    it.multi_count = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(8, 1));
    return it;
  endfunction

  // Directed corners: field extremes, every command, counts out of range
  task automatic test_directed();
    branch_item_t it;
    it = '0;
    it.command = tbdp_pkg::CMD_LOOKUP; it.pc = 32'hffff_fffc; it.instr_size = 4'd4;
    it.next_pc = 32'h0;
    send_branch(it);
    it.command = tbdp_pkg::CMD_UPDATE; it.saved_choice = 1'b1; it.saved_history = 8'hff;
    it.saved_bimodal_pred = 1'b1;
    send_branch(it);
    it.instr_size = 4'd15; it.next_pc = 32'hffff_ffff;
    it.saved_two_level_dir = 1'b1;
    send_branch(it);
    it.command = tbdp_pkg::CMD_LOOKUP; it.unconditional = 1'b1; send_branch(it);
    it.unconditional = 1'b0; it.internal_branch = 1'b1; send_branch(it);
    it.command = tbdp_pkg::CMD_NONE; send_branch(it);
    it.internal_branch = 1'b0;
    it.command = tbdp_pkg::CMD_MULTI; it.multi_count = 4'd0; send_branch(it);
    write_mode(tbdp_pkg::MODE_TWOLEVEL);
    for (int c = 0; c < 16; c += 5) begin
      it.command = tbdp_pkg::CMD_UPDATE; it.next_pc = $urandom();
      it.saved_history = hist_reg;
      send_branch(it);
      it.command = tbdp_pkg::CMD_MULTI; it.multi_count = 4'(c == 15 ? 15 : c);
      send_branch(it);
    end
    it.multi_count = 4'd8; send_branch(it);
  endtask

  task automatic test_random_mode(input logic [2:0] m, input int n);
    logic [31:0] base;
    write_mode(m);
    base = $urandom();
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_results();
      send_branch(random_branch(base));
    end
  endtask

  task automatic test_all_modes(input int s_pct, input int r_pct, input int n);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int m = 0; m < 8; m++) test_random_mode(3'(m), n);
    test_random_mode(tbdp_pkg::MODE_COMBINED, n);
  endtask

  initial begin
    send_idle_pct = 8;
    recv_idle_pct = 78;
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    pred_mode = tbdp_pkg::MODE_COMBINED;
    hist_reg  = '0;
    foreach (bim_ctr[i]) bim_ctr[i] = tbdp_pkg::CTR_RESET;
    foreach (pat_ctr[i]) pat_ctr[i] = tbdp_pkg::CTR_RESET;
    foreach (cho_ctr[i]) cho_ctr[i] = tbdp_pkg::CTR_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_all_modes(8, 78, 75);
    test_all_modes(78, 8, 75);
    test_all_modes(0, 0, 75);

    drain_results();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
